// ----- design/wcs_pkg.sv -----
package wcs_pkg;

   localparam int SLOTS    = 4;
   localparam int COUNT_W  = 16;
   localparam int PROB_W   = 16;
   localparam int CSR_W    = 3;
   localparam int CSR_RESET_VAL = 4;
   localparam int MIN_ACTIVE = 2;

   localparam int WEIGHT_W = COUNT_W + PROB_W;
   localparam int CUM_W    = WEIGHT_W + $clog2(SLOTS);
   localparam int PROD_W   = CUM_W + PROB_W;
   localparam int PSUM_W   = PROB_W + $clog2(SLOTS);
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int ACT_W    = $clog2(SLOTS + 1);

   localparam int IN_BITS    = SLOTS * COUNT_W + SLOTS * PROB_W;
   localparam int REQ_DATA_W = ((IN_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((IDX_W + 7) / 8) * 8;

   localparam int PROB_BASE = SLOTS * COUNT_W;
   localparam int RAND_BASE = SLOTS * COUNT_W + (SLOTS - 1) * PROB_W;

   localparam logic [PROB_W-1:0] PROB_ONE = {PROB_W{1'b1}};

   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [PROB_W-1:0]   prob_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [CUM_W-1:0]    cum_type;
   typedef logic [PROD_W-1:0]   prod_type;
   typedef logic [IDX_W-1:0]    idx_type;

   // what the pick stage needs besides the per-lane sums and nonzero flags
   typedef struct packed {
      cum_type  total;
      prob_type rand_frac;
   } pick_ctl_type;

endpackage

// ----- design/wcs_lane.sv -----
module wcs_lane (
   input  logic              clock,
   input  logic              load,
   input  logic              soft_on,
   input  wcs_pkg::count_type count,
   input  wcs_pkg::prob_type  prob,
   output wcs_pkg::weight_type weight_ff
);
   import wcs_pkg::*;

   weight_type weight_in;

   always_comb begin
      if (soft_on) begin
         weight_in = WEIGHT_W'(prob) * WEIGHT_W'(count);
      end else begin
         weight_in = WEIGHT_W'(count);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         weight_ff <= weight_in;
      end
   end

endmodule

// ----- design/wcs_pick.sv -----
module wcs_pick (
   input  logic                     clock,
   input  logic                     load,
   input  wcs_pkg::cum_type [wcs_pkg::SLOTS-1:0] cum,
   input  logic [wcs_pkg::SLOTS-1:0] nonzero,
   input  wcs_pkg::pick_ctl_type    ctl,
   output wcs_pkg::idx_type         chosen_ff,
   output logic                     found_ff
);
   import wcs_pkg::*;

   prod_type            target;
   prod_type            lhs [SLOTS];
   logic [SLOTS-1:0]    hit;
   idx_type             chosen_in;
   logic                found_in;

   assign target = PROD_W'(ctl.total) * PROD_W'(ctl.rand_frac);

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         // cum * 65535 as a shift and subtract
         lhs[i] = {cum[i], {PROB_W{1'b0}}} - PROD_W'(cum[i]);
         hit[i] = nonzero[i] && (lhs[i] >= target);
      end
   end

   always_comb begin
      chosen_in = '0;
      found_in  = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            chosen_in = IDX_W'(i);
            found_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chosen_ff <= chosen_in;
         found_ff  <= found_in;
      end
   end

endmodule

// ----- design/weighted_category_sampler.sv -----
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata counts, probs, random; tuser soft flag
// rsp     | out | rsp_tvalid/rsp_tready | tdata chosen slot; tuser found flag
// csr     | in  | csr_valid/csr_ready   | csr_data categories in use, always ready
// one word per cycle while the receiver keeps rsp_tready high; stages: lane multipliers, running sums,
// then the r*total multiply with lane compares and priority pick
// each stage moves when the next one is empty or moving, so stalls fill bubbles
// reset is synchronous and clears the valid bits and sets categories in use to 4
module weighted_category_sampler (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // count_slot0..3, soft_prob_slot0..2, random_fraction
   input  logic [wcs_pkg::REQ_DATA_W-1:0] req_tdata,
   // soft_present
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // chosen_slot, zero padded
   output logic [wcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // value_found
   output logic [0:0] rsp_tuser,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [wcs_pkg::CSR_W-1:0] csr_data
);
   import wcs_pkg::*;

   logic [CSR_W-1:0]  cats_ff;
   logic [ACT_W-1:0]  act;
   logic              v1_ff, v2_ff, v3_ff;
   logic              rdy1, rdy2, rdy3;
   logic              load1, load2, load3;
   prob_type          rand1_ff, rand2_ff;
   logic              soft_on;
   prob_type          prob_ext [SLOTS];
   prob_type          lane_prob [SLOTS];
   logic [PSUM_W-1:0] psum;
   prob_type          last_p;
   weight_type        weight [SLOTS];
   cum_type [SLOTS-1:0] cum_in, cum_ff;
   logic [SLOTS-1:0]  nz_in, nz_ff;
   pick_ctl_type      ctl;
   idx_type           chosen;
   logic              found;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cats_ff <= CSR_W'(CSR_RESET_VAL);
      end else if (csr_valid && csr_ready) begin
         cats_ff <= csr_data;
      end
   end

   always_comb begin
      if (int'(cats_ff) < MIN_ACTIVE) begin
         act = ACT_W'(MIN_ACTIVE);
      end else if (int'(cats_ff) > SLOTS) begin
         act = ACT_W'(SLOTS);
      end else begin
         act = ACT_W'(cats_ff);
      end
   end

   assign rdy3 = !v3_ff || rsp_tready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign load1 = req_tvalid && rdy1;
   assign load2 = v1_ff && rdy2;
   assign load3 = v2_ff && rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   assign soft_on = req_tuser[0];

   // probabilities of the active slots, remainder to the last active one
   always_comb begin
      psum = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (i < SLOTS - 1) begin
            prob_ext[i] = req_tdata[PROB_BASE + i * PROB_W +: PROB_W];
         end else begin
            prob_ext[i] = '0;
         end
         if (i + 1 < int'(act)) begin
            psum = psum + PSUM_W'(prob_ext[i]);
         end
      end
      if (psum >= PSUM_W'(PROB_ONE)) begin
         last_p = '0;
      end else begin
         last_p = PROB_ONE - psum[PROB_W-1:0];
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (i + 1 < int'(act)) begin
            lane_prob[i] = prob_ext[i];
         end else if (i + 1 == int'(act)) begin
            lane_prob[i] = last_p;
         end else begin
            lane_prob[i] = '0;
         end
      end
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_lane
      wcs_lane u_lane (
         .clock     (clock),
         .load      (load1),
         .soft_on   (soft_on),
         .count     (req_tdata[g * COUNT_W +: COUNT_W]),
         .prob      (lane_prob[g]),
         .weight_ff (weight[g])
      );
   end

   always_ff @(posedge clock) begin
      if (load1) rand1_ff <= req_tdata[RAND_BASE +: PROB_W];
      if (load2) begin
         rand2_ff <= rand1_ff;
         cum_ff   <= cum_in;
         nz_ff    <= nz_in;
      end
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         if (i == 0) begin
            cum_in[i] = CUM_W'(weight[i]);
         end else begin
            cum_in[i] = cum_in[i-1] + CUM_W'(weight[i]);
         end
         nz_in[i] = (weight[i] != '0);
      end
   end

   assign ctl.total     = cum_ff[SLOTS-1];
   assign ctl.rand_frac = rand2_ff;

   wcs_pick u_pick (
      .clock     (clock),
      .load      (load3),
      .cum       (cum_ff),
      .nonzero   (nz_ff),
      .ctl       (ctl),
      .chosen_ff (chosen),
      .found_ff  (found)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = RSP_DATA_W'(chosen);
   assign rsp_tuser  = found;

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> chosen == '0)
      else $error("no-value word carries a nonzero slot");

   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      load3 && ctl.total != '0 |=> found)
      else $error("nonzero total weight gave no slot");

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      load3 && ctl.total == '0 |=> !found)
      else $error("zero total weight gave a slot");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rsp_tready |=> v3_ff && $stable(chosen) && $stable(found))
      else $error("stalled result changed");

   a_act_range: assert property (@(posedge clock) disable iff (reset)
      int'(act) >= MIN_ACTIVE && int'(act) <= SLOTS)
      else $error("active slot count out of range");

endmodule

// ----- bench/sampler_checker.sv -----
`timescale 1ns / 1ps

module sampler_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [wcs_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]                     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [wcs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [0:0]                     rsp_tuser,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [wcs_pkg::CSR_W-1:0]      csr_data,
   output int                             fail_count,
   output int                             words_pending
);
   import wcs_pkg::*;

   typedef struct packed {
      idx_type slot;
      logic    found;
   } pick_type;

   pick_type       picks_due[$];
   logic [CSR_W-1:0] active_setting;
   int             mismatches = 0;

   assign fail_count = mismatches;

   function automatic pick_type expected_pick(input logic [REQ_DATA_W-1:0] d,
                                               input logic soft_on,
                                               input logic [CSR_W-1:0] setting);
      longint unsigned weight [SLOTS];
      longint unsigned prob, count, psum, last_prob, total, cum, target;
      int              n;
      bit              done;
      pick_type        res;
      n = (setting < MIN_ACTIVE) ? MIN_ACTIVE : ((setting > SLOTS) ? SLOTS : int'(setting));
      psum = 0;
      total = 0;
      cum = 0;
      done = 0;
      res = '0;
      for (int i = 0; i < SLOTS; i++) begin
         weight[i] = soft_on ? 0 : longint'(d[i*COUNT_W +: COUNT_W]);
      end
      if (soft_on) begin
         for (int i = 0; i < n - 1; i++) begin
            prob = d[PROB_BASE + i*PROB_W +: PROB_W];
            count = d[i*COUNT_W +: COUNT_W];
            psum += prob;
            weight[i] = prob * count;
         end
         // remainder probability goes to the last active slot
         last_prob = (psum >= longint'(PROB_ONE)) ? 0 : longint'(PROB_ONE) - psum;
         count = d[(n-1)*COUNT_W +: COUNT_W];
         weight[n-1] = last_prob * count;
      end
      for (int i = 0; i < SLOTS; i++) total += weight[i];
      if (total == 0) return res;
      target = total * longint'(d[RAND_BASE +: PROB_W]);
      for (int i = 0; i < SLOTS; i++) begin
         cum += weight[i];
         if (!done && weight[i] != 0 && cum * longint'(PROB_ONE) >= target) begin
            res.slot = idx_type'(i);
            res.found = 1'b1;
            done = 1;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      pick_type due;
      if (reset) begin
         picks_due.delete();
         active_setting = CSR_W'(CSR_RESET_VAL);
      end else begin
         if (csr_valid && csr_ready) active_setting = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (picks_due.size() == 0) begin
               $display("%0t: result word with nothing expected, slot %0d found %0d",
                        $time, rsp_tdata[IDX_W-1:0], rsp_tuser[0]);
               mismatches++;
            end else begin
               due = picks_due.pop_front();
               if (rsp_tdata[IDX_W-1:0] !== due.slot) begin
                  $display("%0t: chosen_slot mismatch, expected %0d actual %0d",
                           $time, due.slot, rsp_tdata[IDX_W-1:0]);
                  mismatches++;
               end
               if (rsp_tuser[0] !== due.found) begin
                  $display("%0t: value_found mismatch, expected %0d actual %0d",
                           $time, due.found, rsp_tuser[0]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            picks_due = {picks_due,
                         expected_pick(req_tdata, req_tuser[0], active_setting)};
         end
      end
      words_pending <= picks_due.size();
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import wcs_pkg::*;

   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_WORDS    = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_W-1:0]      csr_data = '0;

   int fail_count;
   int words_pending;
   int stall_cycles = 0;
   bit steady = 1'b0;
   bit hold_ask = 1'b0;
   bit hold_done = 1'b0;

   always #5 clock = ~clock;

   weighted_category_sampler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   sampler_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   function automatic logic [REQ_DATA_W-1:0] make_word(
      input logic [COUNT_W-1:0] c0, c1, c2, c3,
      input logic [PROB_W-1:0]  p0, p1, p2, frac);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[0*COUNT_W +: COUNT_W] = c0;
      d[1*COUNT_W +: COUNT_W] = c1;
      d[2*COUNT_W +: COUNT_W] = c2;
      d[3*COUNT_W +: COUNT_W] = c3;
      d[PROB_BASE + 0*PROB_W +: PROB_W] = p0;
      d[PROB_BASE + 1*PROB_W +: PROB_W] = p1;
      d[PROB_BASE + 2*PROB_W +: PROB_W] = p2;
      d[RAND_BASE +: PROB_W] = frac;
      return d;
   endfunction

   function automatic logic [COUNT_W-1:0] random_count();
      int k;
      k = $urandom_range(99);
      if (k < 25) return '0;
      if (k < 35) return '1;
      if (k < 60) return COUNT_W'($urandom_range(1, 15));
      return COUNT_W'($urandom);
   endfunction

   // mostly probabilities that sum below one, some that overflow
   function automatic logic [PROB_W-1:0] random_prob();
      int k;
      k = $urandom_range(99);
      if (k < 15) return '0;
      if (k < 25) return PROB_ONE;
      if (k < 75) return PROB_W'($urandom_range(1, 21845));
      return PROB_W'($urandom);
   endfunction

   function automatic logic [PROB_W-1:0] random_fraction();
      int k;
      k = $urandom_range(99);
      if (k < 10) return '0;
      if (k < 20) return PROB_ONE;
      return PROB_W'($urandom);
   endfunction

   task automatic send_word(input logic [REQ_DATA_W-1:0] d, input logic soft_on);
      while (!steady && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= soft_on;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random_word();
      logic [REQ_DATA_W-1:0] d;
      d = make_word(random_count(), random_count(), random_count(), random_count(),
                    random_prob(), random_prob(), random_prob(), random_fraction());
      send_word(d, 1'($urandom_range(1)));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   task automatic write_setting(input logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random backpressure, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_ask && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= steady || ($urandom_range(99) >= 20);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
      begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[weighted_category_sampler] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int setting_order [8] = '{2, 3, 0, 7, 1, 5, 6, 4};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset setting of four slots
      send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      send_word(make_word(0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b1);
      send_word(make_word('1, '1, '1, '1, '1, '1, '1, '1), 1'b1);
      send_word(make_word('1, '1, '1, '1, '1, '1, '1, '1), 1'b0);
      send_word(make_word('1, '1, '1, '1, 0, 0, 0, 0), 1'b0);
      send_word(make_word(0, 0, 0, 5, 0, 0, 0, 0), 1'b0);
      send_word(make_word(1, 1, 1, 1, 0, 0, 0, '1), 1'b0);
      send_word(make_word(5, 5, 5, 5, 0, 0, 0, 0), 1'b1);
      send_word(make_word(1, 1, 1, '1, 21845, 21845, 21845, '1), 1'b1);
      send_word(make_word(0, 7, 7, 7, 30000, 20000, 10000, 0), 1'b1);
      send_word(make_word(0, 0, 0, 0, 30000, 20000, 10000, 12345), 1'b1);
      send_word(make_word(3, 3, 3, 3, 40000, 40000, 0, '1), 1'b1);
      send_word(make_word(2, 2, 2, 2, 0, 0, 0, 32767), 1'b0);
      send_word(make_word(2, 2, 2, 2, 0, 0, 0, 32768), 1'b0);
      send_word(make_word(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                          16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA), 1'b1);
      send_word(make_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                          16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555), 1'b0);

      foreach (setting_order[ph]) begin
         wait_drained();
         write_setting(CSR_W'(setting_order[ph]));
         if (ph == 0) begin
            // two slots: probabilities of inactive slots ignored
            send_word(make_word(0, 0, 9, 9, 30000, '1, '1, 0), 1'b1);
            send_word(make_word(4, 4, 9, 9, 30000, '1, '1, '1), 1'b1);
            send_word(make_word(4, 0, 0, 9, '1, 0, 0, '1), 1'b0);
            send_word(make_word(4, 4, 0, 0, '1, 0, 0, '1), 1'b1);
         end
         // one phase without idling, with a long receiver hold
         steady = (ph == 2);
         if (ph == 2) hold_ask = 1'b1;
         repeat (PHASE_WORDS) send_random_word();
         steady = 1'b0;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("[weighted_category_sampler] OK");
      end else begin
         $display("[weighted_category_sampler] ERROR");
      end
      $finish;
   end

endmodule
